/* src/fli_chunk_decoder_assert.svh */
// assertion macros for the chunk decoder; only fcd_parser includes them
// no dependencies; include from inside a module body
`ifndef FLI_CHUNK_DECODER_ASSERT_SVH
`define FLI_CHUNK_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FCD_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcd assertion failed");

// consequent must hold in the cycle after the antecedent
`define FCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcd assertion failed");

`endif

/* src/fcd_pkg.sv */
// types and constants for the chunk decoder
// no dependencies; used by every module of the block
package fcd_pkg;

    typedef struct packed {
        logic        req_type;
        logic [15:0] chunk_kind;
        logic [7:0]  body_byte;
    } t_request;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [15:0] pixel_addr;
        logic [16:0] run_length;
        logic [7:0]  pixel_value;
        logic [7:0]  color_index;
        logic [1:0]  color_component;
    } t_result;

    // request types
    localparam logic REQ_OPEN = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    // chunk kinds on open
    localparam logic [15:0] KIND_PALETTE    = 16'd11;
    localparam logic [15:0] KIND_LINE_DELTA = 16'd12;
    localparam logic [15:0] KIND_CLEAR      = 16'd13;
    localparam logic [15:0] KIND_BYTE_RUN   = 16'd15;
    localparam logic [15:0] KIND_COPY       = 16'd16;

    // result kinds
    localparam logic [1:0] OUT_PIXEL   = 2'd0;
    localparam logic [1:0] OUT_FILL    = 2'd1;
    localparam logic [1:0] OUT_PALETTE = 2'd2;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd320;
    localparam logic [10:0] FRAME_HEIGHT_RESET = 11'd200;

    // write address saturates here
    localparam logic [16:0] ADDR_MAX = 17'h1FFFF;

endpackage

/* src/fcd_in_stage.sv */
// input register of the chunk decoder
// depends on fcd_pkg for the request type
module fcd_in_stage
    import fcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_request i_data,
    output logic     o_valid,
    output t_request o_data,
    input  logic     i_take
);

    logic     r_valid;
    t_request r_data;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

/* src/fcd_parser.sv */
// chunk body parser: parser state and the result of one request
// depends on fcd_pkg and the assertion macro header
module fcd_parser
    import fcd_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_request    i_req,
    input  logic [10:0] i_frame_width,
    input  logic [10:0] i_frame_height,
    output logic        o_emit,
    output t_result     o_result
);

    `include "fli_chunk_decoder_assert.svh"

    localparam int unsigned LIMIT_RAW = (FRAME_BYTES > 65536) ? 65536 : FRAME_BYTES;
    localparam logic [16:0] FRAME_LIMIT = 17'(LIMIT_RAW);

    typedef enum logic [4:0] {
        PH_IDLE, PH_PAL_N_LO, PH_PAL_N_HI, PH_PAL_SKIP, PH_PAL_CHANGE, PH_PAL_RGB,
        PH_LC_Y_LO, PH_LC_Y_HI, PH_LC_N_LO, PH_LC_N_HI, PH_LC_PKTS, PH_LC_SKIP,
        PH_LC_COUNT, PH_LC_REP, PH_LC_LIT,
        PH_BR_PKTS, PH_BR_COUNT, PH_BR_LIT, PH_BR_REP, PH_COPY
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_word_low_byte, n_word_low_byte;
    logic [15:0] r_row_current, n_row_current;
    logic [16:0] r_row_end, n_row_end;
    logic [15:0] r_packets_left, n_packets_left;
    logic [8:0]  r_items_left, n_items_left;
    logic [16:0] r_write_addr, n_write_addr;
    logic [7:0]  r_palette_index, n_palette_index;
    logic [1:0]  r_component_step, n_component_step;

    logic        fill_req;
    logic [16:0] fill_addr;
    logic [16:0] fill_len;
    logic [7:0]  fill_val;
    logic        pal_emit;
    logic        do_lc_pkt, do_lc_row, do_br_pkt, do_br_row;

    logic [16:0] lc_next;
    logic        lc_end;
    logic [15:0] br_next;
    logic [15:0] pkt_dec;
    logic [26:0] row_base;
    logic [16:0] room;
    logic [16:0] clip_len;
    logic [7:0]  b;

    function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [16:0] d);
        logic [17:0] s;
        s = {1'b0, a} + {1'b0, d};
        return s[17] ? ADDR_MAX : s[16:0];
    endfunction

    assign b        = i_req.body_byte;
    assign lc_next  = {1'b0, r_row_current} + 17'd1;
    assign lc_end   = (lc_next >= r_row_end) || lc_next[16];
    assign br_next  = r_row_current + 16'd1;
    assign pkt_dec  = r_packets_left - 16'd1;
    assign row_base = {11'd0, r_row_current} * {16'd0, i_frame_width};

    always_comb begin
        n_phase          = r_phase;
        n_word_low_byte  = r_word_low_byte;
        n_row_current    = r_row_current;
        n_row_end        = r_row_end;
        n_packets_left   = r_packets_left;
        n_items_left     = r_items_left;
        n_write_addr     = r_write_addr;
        n_palette_index  = r_palette_index;
        n_component_step = r_component_step;
        fill_req         = 1'b0;
        fill_addr        = r_write_addr;
        fill_len         = 17'd1;
        fill_val         = b;
        pal_emit         = 1'b0;
        do_lc_pkt        = 1'b0;
        do_lc_row        = 1'b0;
        do_br_pkt        = 1'b0;
        do_br_row        = 1'b0;

        if (i_req.req_type == REQ_OPEN) begin
            n_phase      = PH_IDLE;
            n_write_addr = '0;
            case (i_req.chunk_kind)
                KIND_PALETTE:    n_phase = PH_PAL_N_LO;
                KIND_LINE_DELTA: n_phase = PH_LC_Y_LO;
                KIND_CLEAR: begin
                    fill_req  = 1'b1;
                    fill_addr = '0;
                    fill_len  = FRAME_LIMIT;
                    fill_val  = 8'd0;
                end
                KIND_BYTE_RUN: begin
                    n_row_current = '0;
                    n_row_end     = {6'd0, i_frame_height};
                    if (i_frame_height != 11'd0) begin
                        n_phase = PH_BR_PKTS;
                    end
                end
                KIND_COPY:       n_phase = PH_COPY;
                default:         ;
            endcase
        end else begin
            case (r_phase)
                PH_PAL_N_LO: begin
                    n_word_low_byte = b;
                    n_phase         = PH_PAL_N_HI;
                end
                PH_PAL_N_HI: begin
                    n_packets_left = {b, r_word_low_byte};
                    n_phase = ({b, r_word_low_byte} == 16'd0) ? PH_IDLE : PH_PAL_SKIP;
                end
                PH_PAL_SKIP: begin
                    n_palette_index = b;
                    n_phase         = PH_PAL_CHANGE;
                end
                PH_PAL_CHANGE: begin
                    // a change byte of zero means a full palette
                    n_items_left     = (b == 8'd0) ? 9'd256 : {1'b0, b};
                    n_component_step = 2'd0;
                    n_phase          = PH_PAL_RGB;
                end
                PH_PAL_RGB: begin
                    pal_emit = 1'b1;
                    if (r_component_step != 2'd2) begin
                        n_component_step = r_component_step + 2'd1;
                    end else begin
                        n_component_step = 2'd0;
                        n_palette_index  = r_palette_index + 8'd1;
                        n_items_left     = r_items_left - 9'd1;
                        if (r_items_left == 9'd1) begin
                            n_packets_left = pkt_dec;
                            n_phase = (pkt_dec == 16'd0) ? PH_IDLE : PH_PAL_SKIP;
                        end
                    end
                end
                PH_LC_Y_LO: begin
                    n_word_low_byte = b;
                    n_phase         = PH_LC_Y_HI;
                end
                PH_LC_Y_HI: begin
                    n_row_current = {b, r_word_low_byte};
                    n_phase       = PH_LC_N_LO;
                end
                PH_LC_N_LO: begin
                    n_word_low_byte = b;
                    n_phase         = PH_LC_N_HI;
                end
                PH_LC_N_HI: begin
                    n_row_end = {1'b0, r_row_current} + {1'b0, b, r_word_low_byte};
                    n_phase = ({b, r_word_low_byte} == 16'd0) ? PH_IDLE : PH_LC_PKTS;
                end
                PH_LC_PKTS: begin
                    n_write_addr   = (row_base > 27'(ADDR_MAX)) ? ADDR_MAX : row_base[16:0];
                    n_packets_left = {8'd0, b};
                    if (b == 8'd0) begin
                        do_lc_row = 1'b1;
                    end else begin
                        n_phase = PH_LC_SKIP;
                    end
                end
                PH_LC_SKIP: begin
                    n_write_addr = sat_add(r_write_addr, {9'd0, b});
                    n_phase      = PH_LC_COUNT;
                end
                PH_LC_COUNT: begin
                    if (b[7]) begin
                        n_items_left = 9'd256 - {1'b0, b};
                        n_phase      = PH_LC_REP;
                    end else if (b != 8'd0) begin
                        n_items_left = {1'b0, b};
                        n_phase      = PH_LC_LIT;
                    end else begin
                        do_lc_pkt = 1'b1;
                    end
                end
                PH_LC_REP: begin
                    fill_req     = 1'b1;
                    fill_len     = {8'd0, r_items_left};
                    n_write_addr = sat_add(r_write_addr, {8'd0, r_items_left});
                    do_lc_pkt    = 1'b1;
                end
                PH_LC_LIT: begin
                    fill_req     = 1'b1;
                    n_write_addr = sat_add(r_write_addr, 17'd1);
                    n_items_left = r_items_left - 9'd1;
                    do_lc_pkt    = (r_items_left == 9'd1);
                end
                PH_BR_PKTS: begin
                    n_packets_left = {8'd0, b};
                    if (b == 8'd0) begin
                        do_br_row = 1'b1;
                    end else begin
                        n_phase = PH_BR_COUNT;
                    end
                end
                PH_BR_COUNT: begin
                    // negative count is literal bytes here, the reverse of line delta
                    if (b[7]) begin
                        n_items_left = 9'd256 - {1'b0, b};
                        n_phase      = PH_BR_LIT;
                    end else begin
                        n_items_left = {1'b0, b};
                        n_phase      = PH_BR_REP;
                    end
                end
                PH_BR_LIT: begin
                    fill_req     = 1'b1;
                    n_write_addr = sat_add(r_write_addr, 17'd1);
                    n_items_left = r_items_left - 9'd1;
                    do_br_pkt    = (r_items_left == 9'd1);
                end
                PH_BR_REP: begin
                    fill_req     = 1'b1;
                    fill_len     = {8'd0, r_items_left};
                    n_write_addr = sat_add(r_write_addr, {8'd0, r_items_left});
                    do_br_pkt    = 1'b1;
                end
                PH_COPY: begin
                    fill_req     = 1'b1;
                    n_write_addr = sat_add(r_write_addr, 17'd1);
                end
                default: ;
            endcase
        end

        if (do_lc_pkt) begin
            n_packets_left = pkt_dec;
            if (pkt_dec == 16'd0) begin
                do_lc_row = 1'b1;
            end else begin
                n_phase = PH_LC_SKIP;
            end
        end
        if (do_lc_row) begin
            if (lc_end) begin
                n_phase = PH_IDLE;
            end else begin
                n_row_current = lc_next[15:0];
                n_phase       = PH_LC_PKTS;
            end
        end
        if (do_br_pkt) begin
            n_packets_left = pkt_dec;
            if (pkt_dec == 16'd0) begin
                do_br_row = 1'b1;
            end else begin
                n_phase = PH_BR_COUNT;
            end
        end
        if (do_br_row) begin
            // row counter advances even when the chunk ends
            n_row_current = br_next;
            n_phase = ({1'b0, br_next} >= r_row_end) ? PH_IDLE : PH_BR_PKTS;
        end
    end

    // clip fills at the end of the frame
    assign room     = FRAME_LIMIT - fill_addr;
    assign clip_len = (fill_len > room) ? room : fill_len;

    assign o_emit = pal_emit
                 || (fill_req && (fill_addr < FRAME_LIMIT) && (fill_len != 17'd0));

    always_comb begin
        if (pal_emit) begin
            o_result.out_kind        = OUT_PALETTE;
            o_result.pixel_addr      = 16'd0;
            o_result.run_length      = 17'd1;
            o_result.pixel_value     = b;
            o_result.color_index     = r_palette_index;
            o_result.color_component = r_component_step;
        end else begin
            o_result.out_kind        = (clip_len == 17'd1) ? OUT_PIXEL : OUT_FILL;
            o_result.pixel_addr      = fill_addr[15:0];
            o_result.run_length      = clip_len;
            o_result.pixel_value     = fill_val;
            o_result.color_index     = 8'd0;
            o_result.color_component = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_word_low_byte  <= '0;
            r_row_current    <= '0;
            r_row_end        <= '0;
            r_packets_left   <= '0;
            r_items_left     <= '0;
            r_write_addr     <= '0;
            r_palette_index  <= '0;
            r_component_step <= '0;
        end else if (i_fire) begin
            r_phase          <= n_phase;
            r_word_low_byte  <= n_word_low_byte;
            r_row_current    <= n_row_current;
            r_row_end        <= n_row_end;
            r_packets_left   <= n_packets_left;
            r_items_left     <= n_items_left;
            r_write_addr     <= n_write_addr;
            r_palette_index  <= n_palette_index;
            r_component_step <= n_component_step;
        end
    end

    `FCD_ASSERT_HOLDS(a_pal_fixed, i_clk, i_rst_n, o_emit && pal_emit, o_result.pixel_addr == 16'd0 && o_result.run_length == 17'd1)
    `FCD_ASSERT_HOLDS(a_fill_nonzero, i_clk, i_rst_n, o_emit && !pal_emit, o_result.run_length != 17'd0)
    `FCD_ASSERT_HOLDS(a_items_live, i_clk, i_rst_n, r_phase == PH_LC_LIT || r_phase == PH_LC_REP || r_phase == PH_BR_LIT || r_phase == PH_PAL_RGB, r_items_left != 9'd0)
    `FCD_ASSERT_NEXT(a_pal_advance, i_clk, i_rst_n, i_fire && i_req.req_type == REQ_BYTE && r_phase == PH_PAL_RGB && r_component_step == 2'd2, r_palette_index == $past(r_palette_index) + 8'd1 && r_component_step == 2'd0)

endmodule

/* src/fcd_out_stage.sv */
// result register of the chunk decoder
// depends on fcd_pkg for the result type
module fcd_out_stage
    import fcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_data,
    output logic    o_can_take,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_valid;
    t_result r_data;

    assign o_can_take = !r_valid || !i_stall;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_load) begin
            r_data <= i_data;
        end
    end

endmodule

/* src/fli_chunk_decoder.sv */
// Chunk body decoder for FLI animations. Requests open a chunk (palette, line delta, clear,
// byte run, copy) or deliver one body byte; each request gives at most one result: a pixel
// write, a clipped fill run or a palette component write. One request is taken every clock
// cycle when the output side is not stalled; a result leaves through the input register,
// the combinational parser step and the result register. The user writes frame_width and
// frame_height through the plain config port only while idle; the block does not enforce it.
// Depends on fcd_pkg, fcd_in_stage, fcd_parser and fcd_out_stage.
module fli_chunk_decoder
    import fcd_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_request    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_data
);

    logic [10:0] r_frame_width;
    logic [10:0] r_frame_height;

    logic     req_valid;
    t_request req_data;
    logic     can_take;
    logic     fire;
    logic     emit;
    t_result  result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign fire = req_valid && can_take;

    fcd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_valid (req_valid),
        .o_data  (req_data),
        .i_take  (can_take)
    );

    fcd_parser #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_req          (req_data),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_emit         (emit),
        .o_result       (result)
    );

    fcd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && emit),
        .i_data     (result),
        .o_can_take (can_take),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_data)
    );

endmodule
